### rtl/multirate_pi_step_controller_defines.svh
// Assertion macros for the multirate PI step controller.
// Included by the top level; depends on nothing else.
`ifndef MULTIRATE_PI_STEP_CONTROLLER_DEFINES_SVH
`define MULTIRATE_PI_STEP_CONTROLLER_DEFINES_SVH

`ifndef ASSERT_OFF
`define MPSC_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);
`define MPSC_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define MPSC_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define MPSC_ASSERT_ALWAYS(lbl, clk_s, prop, msg)
`endif

`endif

### rtl/mpsc_pkg.sv
// Types and constants of the multirate PI step controller.
// Used by multirate_pi_step_controller; depends on nothing else.
package mpsc_pkg;

  localparam int DATA_W    = 64;
  localparam int GAIN_W    = 20;
  localparam int ORD_W     = 4;
  localparam int CMD_W     = 2;
  localparam int STAT_W    = 2;
  localparam int CFG_IDX_W = 3;
  localparam int LOG_W     = 40;
  localparam int LRES_W    = 38;

  localparam logic [DATA_W-1:0] ONE_Q40    = 64'h0000_0100_0000_0000;
  localparam logic [DATA_W-1:0] TINY_ERR   = 64'd110;
  localparam logic [DATA_W-1:0] LN2_Q64    = 64'hB172_17F7_D1CF_79AB;
  localparam logic [DATA_W-1:0] EXP_OFFSET = 64'h0000_0028_0000_0000;
  localparam logic [DATA_W-1:0] SERIES_ONE = 64'h4000_0000_0000_0000;
  localparam logic [LOG_W-1:0]  LOG_OFFSET = 40'h28_0000_0000;
  localparam logic [4:0]        SERIES_LEN = 5'd24;

  localparam logic [GAIN_W-1:0] GAIN_S1_RST  = 20'd11796;
  localparam logic [GAIN_W-1:0] GAIN_S2_RST  = 20'd56361;
  localparam logic [GAIN_W-1:0] GAIN_F1_RST  = 20'd22282;
  localparam logic [GAIN_W-1:0] GAIN_F2_RST  = 20'd52429;
  localparam logic [GAIN_W-1:0] BIAS_DEFAULT = 20'd98304;
  localparam logic [ORD_W-1:0]  ORDER_RST    = 4'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ESTIMATE = 2'd0,
    CMD_UPDATE   = 2'd1,
    CMD_CLEAR    = 2'd2
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_SAT       = 2'd1,
    ST_FAST_ZERO = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_S1    = 3'd0,
    REG_GAIN_S2    = 3'd1,
    REG_GAIN_F1    = 3'd2,
    REG_GAIN_F2    = 3'd3,
    REG_BIAS       = 3'd4,
    REG_FAST_ORDER = 3'd5
  } cfg_reg_t;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_EXEC  = 11'b000_0000_0010,
    S_MUL   = 11'b000_0000_0100,
    S_DIV   = 11'b000_0000_1000,
    S_NORM  = 11'b000_0001_0000,
    S_LOGSQ = 11'b000_0010_0000,
    S_ETERM = 11'b000_0100_0000,
    S_XLN   = 11'b000_1000_0000,
    S_TMUL  = 11'b001_0000_0000,
    S_TDIV  = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_t;

  typedef enum logic [4:0] {
    E_BIAS_S, E_BIAS_F, E_DISPATCH, E_LOG_ESP, E_LOG_EF, E_LOG_EFP, E_LOG_H,
    E_T1, E_T2, E_M, E_LOG_M, E_T3, E_T4, E_T5, E_T6, E_XF, E_XS, E_FIN
  } step_t;

  typedef enum logic [2:0] {
    ACT_MUL, ACT_DIV, ACT_LOG, ACT_TERM, ACT_EXP, ACT_DONE
  } act_t;

endpackage

### rtl/multirate_pi_step_controller.sv
// Multirate PI step-size controller: top level with its sequencer and shared datapath.
// Depends on mpsc_pkg and multirate_pi_step_controller_defines.svh.
//
//   Channel  Handshake             Payload
//   in       in_valid / in_ready   command, slow_step, fast_step, slow_order, slow_error,
//                                  fast_error
//   out      out_valid / out_ready new_slow_step, new_fast_step, status
//   cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// Update and clear commands are the shortest, an estimate with a zero fast step takes
// longer and a full estimate the longest. The run time is set by the one 32x32 multiplier
// (four partial products per 64-bit product, 32 squarings per log2) and the one-bit-per-cycle divider,
// which runs 24 times in each exp2 series. Input is taken only while the sequencer is idle;
// a finished result waits in the output register and blocks nothing but the next finish.
// Synchronous reset restores the gains, the bias, the fast order and both stored errors.
`include "multirate_pi_step_controller_defines.svh"

module multirate_pi_step_controller (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [mpsc_pkg::CMD_W-1:0]       command,
  input  logic [mpsc_pkg::DATA_W-1:0]      slow_step,
  input  logic [mpsc_pkg::DATA_W-1:0]      fast_step,
  input  logic [mpsc_pkg::ORD_W-1:0]       slow_order,
  input  logic [mpsc_pkg::DATA_W-1:0]      slow_error,
  input  logic [mpsc_pkg::DATA_W-1:0]      fast_error,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mpsc_pkg::DATA_W-1:0]      new_slow_step,
  output logic [mpsc_pkg::DATA_W-1:0]      new_fast_step,
  output logic [mpsc_pkg::STAT_W-1:0]      status,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mpsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mpsc_pkg::GAIN_W-1:0]      cfg_data
);
  import mpsc_pkg::*;

  logic [GAIN_W-1:0] k11, k12, k21, k22, bias;
  logic [ORD_W-1:0]  p_ord;

  state_t state, ret, dret;
  step_t  step, step_next;

  logic [CMD_W-1:0]  cmd;
  logic [DATA_W-1:0] hslow, hfast, serr, ferr;
  logic [ORD_W-1:0]  s_ord;
  logic [DATA_W-1:0] es1, ef1, prev_s, prev_f;
  logic signed [LOG_W-1:0]  l1, lp, lf1, lfp;
  logic signed [DATA_W-1:0] acc_s, acc_f;
  logic [DATA_W-1:0] hs, hf, eres;
  logic              sat_f;

  logic [DATA_W-1:0]   ma, mb;
  logic [2*DATA_W-1:0] prod;
  logic [1:0]          mcnt;

  logic [DATA_W-1:0] dq, dd;
  logic [DATA_W:0]   rem;
  logic [5:0]        dcnt;

  logic [DATA_W-1:0] ly;
  logic [5:0]        le;
  logic [2:0]        ncnt;
  logic [31:0]       lfrac;
  logic [4:0]        lcnt;
  logic [LRES_W-1:0] lres;

  logic              tneg;
  logic [24:0]       tden;
  logic [DATA_W-1:0] xx, xsum;
  logic [4:0]        xk;
  logic [5:0]        xn;

  // Combinational helpers.
  logic [ORD_W-1:0] s_eff, p_eff;
  logic [20:0] ks, kf;
  logic [25:0] pks;
  logic [24:0] pk11;
  logic [4:0]  d_s, d_f;
  logic [8:0]  d_m;
  logic [DATA_W-1:0] bprod;
  logic signed [LOG_W-1:0]  lq40;
  logic signed [DATA_W-1:0] tq;
  logic [DATA_W-1:0] m_ceil;

  act_t              act_kind;
  logic [DATA_W-1:0] act_a, act_b;
  logic [25:0]       term_c;
  logic [8:0]        term_d;
  logic signed [LOG_W-1:0] term_l, term_mag;
  logic signed [DATA_W-1:0] exp_s;

  logic [63:0]         pp;
  logic [6:0]          msh;
  logic [DATA_W:0]     div_r2;
  logic [6:0]          nsh;
  logic                ntop_zero;
  logic [DATA_W-1:0]   ly_sh;
  logic [5:0]          le_sh;
  logic [DATA_W-1:0]   y_sq;
  logic [31:0]         frac_sq;
  logic [DATA_W-1:0]   sum_new;

  function automatic logic [DATA_W-1:0] bias_sat(input logic [2*DATA_W-1:0] p);
    logic [DATA_W-1:0] r;
    r = (p[127:80] != '0) ? '1 : p[79:16];
    return (r < TINY_ERR) ? TINY_ERR : r;
  endfunction

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  assign s_eff = (s_ord == '0) ? 4'd1 : s_ord;
  assign p_eff = (p_ord == '0) ? 4'd1 : p_ord;
  assign ks    = 21'(k11) + 21'(k12);
  assign kf    = 21'(k21) + 21'(k22);
  assign pks   = 26'(ks) * 26'(5'(p_eff) + 5'd1);
  assign pk11  = 25'(k11) * 25'(5'(p_eff) + 5'd1);
  assign d_s   = {s_eff, 1'b0};
  assign d_f   = {p_eff, 1'b0};
  assign d_m   = 9'(d_s) * 9'(p_eff);

  assign bprod  = bias_sat(prod);
  assign lq40   = $signed({2'b00, lres}) - $signed(LOG_OFFSET);
  assign tq     = tneg ? -$signed(dq) : $signed(dq);
  assign m_ceil = dq + ((rem != '0) ? 64'd1 : 64'd0);

  assign pp     = 64'(mcnt[1] ? ma[63:32] : ma[31:0]) * 64'(mcnt[0] ? mb[63:32] : mb[31:0]);
  assign msh    = {2'(mcnt[1]) + 2'(mcnt[0]), 5'b0};
  assign div_r2 = {rem[DATA_W-1:0], dq[DATA_W-1]};

  assign nsh       = 7'd32 >> ncnt;
  assign ntop_zero = ((ly >> (7'd64 - nsh)) == '0);
  assign ly_sh     = ntop_zero ? (ly << nsh) : ly;
  assign le_sh     = ntop_zero ? (le - 6'(nsh)) : le;
  assign y_sq      = prod[127] ? prod[127:64] : prod[126:63];
  assign frac_sq   = {lfrac[30:0], prod[127]};
  assign sum_new   = xsum + dq;

  assign exp_s = $signed(act_a) + $signed(EXP_OFFSET);

  always_comb begin
    act_kind  = ACT_DONE;
    act_a     = '0;
    act_b     = '0;
    step_next = step;
    term_c    = '0;
    term_d    = '0;
    term_l    = '0;
    unique case (step)
      E_BIAS_S: begin
        act_kind = ACT_MUL; act_a = 64'(bias); act_b = serr; step_next = E_BIAS_F;
      end
      E_BIAS_F: begin
        act_kind = ACT_MUL; act_a = 64'(bias); act_b = ferr; step_next = E_DISPATCH;
      end
      E_DISPATCH: begin
        if (cmd == CMD_ESTIMATE && hslow != '0) begin
          act_kind = ACT_LOG; act_a = es1; step_next = E_LOG_ESP;
        end
      end
      E_LOG_ESP: begin
        act_kind = ACT_LOG; act_a = prev_s; step_next = E_LOG_EF;
      end
      E_LOG_EF: begin
        act_kind = ACT_LOG; act_a = ef1; step_next = E_LOG_EFP;
      end
      E_LOG_EFP: begin
        act_kind = ACT_LOG; act_a = prev_f; step_next = E_LOG_H;
      end
      E_LOG_H: begin
        act_kind = ACT_LOG; act_a = hslow; step_next = E_T1;
      end
      E_T1: begin
        act_kind = ACT_TERM; term_c = 26'(ks); term_d = 9'(d_s); term_l = l1;
        step_next = E_T2;
      end
      E_T2: begin
        act_kind = ACT_TERM; term_c = 26'(k11); term_d = 9'(d_s); term_l = lp;
        step_next = E_M;
      end
      E_M: begin
        if (hfast != '0) begin
          act_kind = ACT_DIV; act_a = hslow; act_b = hfast; step_next = E_LOG_M;
        end else begin
          act_kind = ACT_EXP; act_a = acc_s - tq; step_next = E_FIN;
        end
      end
      E_LOG_M: begin
        act_kind = ACT_LOG; act_a = m_ceil; step_next = E_T3;
      end
      E_T3: begin
        act_kind = ACT_TERM; term_c = pks; term_d = d_m; term_l = l1; step_next = E_T4;
      end
      E_T4: begin
        act_kind = ACT_TERM; term_c = 26'(pk11); term_d = d_m; term_l = lp; step_next = E_T5;
      end
      E_T5: begin
        act_kind = ACT_TERM; term_c = 26'(kf); term_d = 9'(d_f); term_l = lf1;
        step_next = E_T6;
      end
      E_T6: begin
        act_kind = ACT_TERM; term_c = 26'(k21); term_d = 9'(d_f); term_l = lfp;
        step_next = E_XF;
      end
      E_XF: begin
        act_kind = ACT_EXP; act_a = acc_f - tq; step_next = E_XS;
      end
      E_XS: begin
        act_kind = ACT_EXP; act_a = acc_s; step_next = E_FIN;
      end
      default: begin
        act_kind = ACT_DONE;
      end
    endcase
    term_mag = term_l[LOG_W-1] ? -term_l : term_l;
    if (act_kind == ACT_TERM) begin
      act_a = 64'(term_c);
      act_b = {24'b0, term_mag};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      k11       <= GAIN_S1_RST;
      k12       <= GAIN_S2_RST;
      k21       <= GAIN_F1_RST;
      k22       <= GAIN_F2_RST;
      bias      <= BIAS_DEFAULT;
      p_ord     <= ORDER_RST;
      prev_s    <= ONE_Q40;
      prev_f    <= ONE_Q40;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_GAIN_S1:    k11 <= cfg_data;
          REG_GAIN_S2:    k12 <= cfg_data;
          REG_GAIN_F1:    k21 <= cfg_data;
          REG_GAIN_F2:    k22 <= cfg_data;
          REG_BIAS:       bias <= (cfg_data == '0) ? BIAS_DEFAULT : cfg_data;
          REG_FAST_ORDER: p_ord <= cfg_data[ORD_W-1:0];
          default: begin
          end
        endcase
      end

      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd   <= command;
            hslow <= slow_step;
            hfast <= fast_step;
            s_ord <= slow_order;
            serr  <= slow_error;
            ferr  <= fast_error;
            step  <= E_BIAS_S;
            state <= S_EXEC;
          end
        end

        S_EXEC: begin
          unique case (step)
            E_BIAS_F: es1 <= bprod;
            E_DISPATCH: begin
              ef1   <= bprod;
              hs    <= '0;
              hf    <= '0;
              sat_f <= 1'b0;
              if (cmd == CMD_UPDATE) begin
                prev_s <= es1;
                prev_f <= bprod;
              end else if (cmd == CMD_CLEAR) begin
                prev_s <= ONE_Q40;
                prev_f <= ONE_Q40;
              end
            end
            E_LOG_ESP: l1 <= lq40;
            E_LOG_EF:  lp <= lq40;
            E_LOG_EFP: lf1 <= lq40;
            E_LOG_H:   lfp <= lq40;
            E_T1:      acc_s <= {{(DATA_W-LOG_W){lq40[LOG_W-1]}}, lq40};
            E_T2:      acc_s <= acc_s + tq;
            E_M:       acc_s <= acc_s - tq;
            E_T3:      acc_f <= acc_s - $signed({26'b0, lres});
            E_T4:      acc_f <= acc_f - tq;
            E_T5:      acc_f <= acc_f + tq;
            E_T6:      acc_f <= acc_f + tq;
            E_XS:      hf <= eres;
            E_FIN:     hs <= eres;
            default: begin
            end
          endcase
          step <= step_next;
          unique case (act_kind)
            ACT_MUL: begin
              ma <= act_a; mb <= act_b; prod <= '0; mcnt <= '0;
              ret <= S_EXEC; state <= S_MUL;
            end
            ACT_DIV: begin
              dq <= act_a; dd <= act_b; rem <= '0; dcnt <= '0;
              dret <= S_EXEC; state <= S_DIV;
            end
            ACT_LOG: begin
              ly <= act_a; le <= 6'd63; ncnt <= '0; state <= S_NORM;
            end
            ACT_TERM: begin
              ma <= act_a; mb <= act_b; prod <= '0; mcnt <= '0;
              tneg <= term_l[LOG_W-1];
              tden <= {term_d, 16'b0};
              ret <= S_ETERM; state <= S_MUL;
            end
            ACT_EXP: begin
              if (exp_s[63]) begin
                eres  <= '0;
                state <= S_EXEC;
              end else if (exp_s[62:32] > 31'd63) begin
                eres  <= '1;
                sat_f <= 1'b1;
                state <= S_EXEC;
              end else begin
                xn   <= exp_s[37:32];
                ma   <= {exp_s[31:0], 32'b0};
                mb   <= LN2_Q64;
                prod <= '0;
                mcnt <= '0;
                ret  <= S_XLN;
                state <= S_MUL;
              end
            end
            default: state <= S_DONE;
          endcase
        end

        S_MUL: begin
          prod <= prod + ({64'b0, pp} << msh);
          mcnt <= mcnt + 2'd1;
          if (mcnt == 2'd3) begin
            state <= ret;
          end
        end

        S_DIV: begin
          if (div_r2 >= {1'b0, dd}) begin
            rem <= div_r2 - {1'b0, dd};
            dq  <= {dq[DATA_W-2:0], 1'b1};
          end else begin
            rem <= div_r2;
            dq  <= {dq[DATA_W-2:0], 1'b0};
          end
          dcnt <= dcnt + 6'd1;
          if (dcnt == 6'd63) begin
            state <= dret;
          end
        end

        S_NORM: begin
          ly   <= ly_sh;
          le   <= le_sh;
          ncnt <= ncnt + 3'd1;
          if (ncnt == 3'd5) begin
            ma <= ly_sh; mb <= ly_sh; prod <= '0; mcnt <= '0;
            lcnt <= '0; lfrac <= '0;
            ret <= S_LOGSQ; state <= S_MUL;
          end
        end

        S_LOGSQ: begin
          ly    <= y_sq;
          lfrac <= frac_sq;
          if (lcnt == 5'd31) begin
            lres  <= {le, frac_sq};
            state <= S_EXEC;
          end else begin
            lcnt <= lcnt + 5'd1;
            ma <= y_sq; mb <= y_sq; prod <= '0; mcnt <= '0;
            ret <= S_LOGSQ; state <= S_MUL;
          end
        end

        S_ETERM: begin
          dq <= prod[DATA_W-1:0]; dd <= 64'(tden); rem <= '0; dcnt <= '0;
          dret <= S_EXEC; state <= S_DIV;
        end

        S_XLN: begin
          xx   <= prod[127:64];
          xsum <= SERIES_ONE;
          xk   <= 5'd1;
          ma <= SERIES_ONE; mb <= prod[127:64]; prod <= '0; mcnt <= '0;
          ret <= S_TMUL; state <= S_MUL;
        end

        S_TMUL: begin
          dq <= prod[127:64]; dd <= 64'(xk); rem <= '0; dcnt <= '0;
          dret <= S_TDIV; state <= S_DIV;
        end

        S_TDIV: begin
          xsum <= sum_new;
          if (xk == SERIES_LEN) begin
            if (xn == 6'd63) begin
              if (sum_new[63]) begin
                eres  <= '1;
                sat_f <= 1'b1;
              end else begin
                eres <= sum_new << 1;
              end
            end else begin
              eres <= sum_new >> (6'd62 - xn);
            end
            state <= S_EXEC;
          end else begin
            xk <= xk + 5'd1;
            ma <= dq; mb <= xx; prod <= '0; mcnt <= '0;
            ret <= S_TMUL; state <= S_MUL;
          end
        end

        S_DONE: begin
          if (!out_valid || out_ready) begin
            new_slow_step <= hs;
            new_fast_step <= (hfast == '0) ? '0 : hf;
            if (cmd != CMD_ESTIMATE) begin
              status <= ST_OK;
            end else if (hfast == '0) begin
              status <= ST_FAST_ZERO;
            end else if (sat_f) begin
              status <= ST_SAT;
            end else begin
              status <= ST_OK;
            end
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  `MPSC_ASSERT(a_div_rem_below, clk, rst, (state == S_DIV && dcnt == 6'd63) |=> (rem < 65'(dd)), "divider remainder not below divisor")
  `MPSC_ASSERT(a_one_item, clk, rst, (in_valid && in_ready) |=> !in_ready, "input taken while busy")
  `MPSC_ASSERT(a_status_code, clk, rst, out_valid |-> (status != 2'd3), "undefined status code")
  `MPSC_ASSERT(a_fast_zero, clk, rst, (out_valid && status == ST_FAST_ZERO) |-> (new_fast_step == '0), "fast step not zero with fast-zero status")
  `MPSC_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> !out_valid, "result valid after reset")

endmodule
